// ===== design/gcva_pkg.sv =====
// Shared types and constants for the grid cell value aggregator.
// Depends on nothing.
package gcva_pkg;
	localparam int GRID_SIZE = 256;
	localparam int AW = 16;
	localparam int DEPTH = 65536;
	localparam int CLR_W = 17;

	typedef enum logic [1:0] {
		MODE_MIN  = 2'd0,
		MODE_MAX  = 2'd1,
		MODE_MEAN = 2'd2,
		MODE_SUM  = 2'd3
	} mode_t;

	localparam logic ACT_ACC  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic clr_step;
		logic cap;
		logic rd;
		logic wr;
		logic div_start;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_read;
		logic need_div;
		logic div_done;
	} sts_t;
endpackage

// ===== design/gcva_ctrl.sv =====
// Controller state machine for the grid cell value aggregator.
// Depends on gcva_pkg.
module gcva_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output gcva_pkg::cmd_t cmd,
	input  gcva_pkg::sts_t sts
);
	import gcva_pkg::*;

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_RD   = 6'b000100,
		S_UPD  = 6'b001000,
		S_DIV  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				busy = 1'b0;
				cmd.cap = start;
				cmd.rd = start;
				if (start) state_d = S_RD;
			end
			S_RD: state_d = S_UPD;
			S_UPD: begin
				if (sts.is_read && sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else begin
					cmd.wr = 1'b1;
					cmd.emit = sts.is_read;
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = S_OUT;
			end
			S_OUT: begin
				cmd.wr = 1'b1;
				cmd.emit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== design/gcva_dp.sv =====
// Datapath for the grid cell value aggregator: cell memory, update and divider.
// Depends on gcva_pkg.
module gcva_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  gcva_pkg::cmd_t      cmd,
	output gcva_pkg::sts_t      sts,
	input  logic [1:0]          mode,
	input  logic                action,
	input  logic [7:0]          row,
	input  logic [7:0]          col,
	input  logic signed [31:0]  sample_value,
	input  logic [23:0]         sample_area,
	output logic signed [31:0]  cell_value,
	output logic                cell_empty,
	output logic                done
);
	import gcva_pkg::*;

	localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};
	localparam logic [39:0] AREA_MAX = {40{1'b1}};

	logic [104:0] mem_q [DEPTH];
	logic [104:0] rdata_q;
	logic [CLR_W-1:0] clr_q;
	logic act_q, in_q;
	logic [AW-1:0] idx_q;
	logic signed [31:0] val_q;
	logic [23:0] area_q;
	logic signed [55:0] prod_q;
	logic [63:0] rem_q, quo_q;
	logic [39:0] dvs_q;
	logic neg_q;
	logic [6:0] cnt_q;

	logic used;
	logic [39:0] tot;
	logic signed [63:0] acc, contrib, accn, sum;
	logic [40:0] tsum;
	logic [104:0] wdata;
	logic signed [31:0] res;
	logic [64:0] trial;
	logic [63:0] mag;

	assign used = rdata_q[104];
	assign tot = rdata_q[103:64];
	assign acc = rdata_q[63:0];
	assign contrib = (mode == MODE_MEAN) ? 64'(prod_q) : 64'(val_q);
	assign sum = acc + contrib;
	assign tsum = {1'b0, tot} + 41'(area_q);
	assign mag = acc[63] ? (64'd0 - acc) : acc;

	always_comb begin
		if (sum[63] != acc[63] && contrib[63] == acc[63]) begin
			accn = acc[63] ? S64_MIN : S64_MAX;
		end else begin
			accn = sum;
		end
		case (mode)
			MODE_MIN: accn = (contrib < acc) ? contrib : acc;
			MODE_MAX: accn = (contrib > acc) ? contrib : acc;
			default: ;
		endcase
		if (act_q == ACT_READ) wdata = '0;
		else if (!used) wdata = {1'b1, 16'd0, area_q, contrib};
		else wdata = {1'b1, tsum[40] ? AREA_MAX : tsum[39:0], accn};
	end

	always_comb begin
		res = '0;
		if (used && tot != '0) begin
			if (acc > 64'sh7FFFFFFF) res = 32'sh7FFFFFFF;
			else if (acc < -64'sh80000000) res = 32'sh80000000;
			else res = acc[31:0];
		end
	end

	assign sts.clr_done = (clr_q == CLR_W'(DEPTH - 1));
	assign sts.is_read = (act_q == ACT_READ);
	assign sts.need_div = in_q && used && (mode == MODE_MEAN) && (tot != '0);
	assign sts.div_done = (cnt_q == 7'd64);
	assign trial = {rem_q, quo_q[63]} - {25'd0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.clr_step) mem_q[clr_q[AW-1:0]] <= {1'b0, 104'd0};
		else if (cmd.wr && in_q) mem_q[idx_q] <= wdata;
		if (cmd.rd) rdata_q <= mem_q[{row, col}];
		if (cmd.cap) begin
			act_q <= action;
			idx_q <= {row, col};
			val_q <= sample_value;
			area_q <= sample_area;
			in_q <= (32'(row) < GRID_SIZE) && (32'(col) < GRID_SIZE);
		end
		prod_q <= 56'(val_q) * $signed({1'b0, area_q});
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= mag;
			dvs_q <= tot;
			neg_q <= acc[63];
			cnt_q <= '0;
		end else if (cmd.div_step && cnt_q != 7'd64) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
			cnt_q <= cnt_q + 7'd1;
		end
		if (cmd.emit) begin
			cell_empty <= !(in_q && used);
			if (sts.need_div) begin
				if (neg_q) cell_value <= (quo_q > 64'h80000000) ? 32'sh80000000
					: 32'(64'd0 - quo_q);
				else cell_value <= (quo_q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : quo_q[31:0];
			end else begin
				cell_value <= (in_q && used) ? res : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			done <= 1'b0;
		end else begin
			if (cmd.clr_step && !sts.clr_done) clr_q <= clr_q + CLR_W'(1);
			done <= cmd.emit;
		end
	end
endmodule

// ===== design/grid_cell_value_aggregator_top.sv =====
// Top level of the grid cell value aggregator: mode register, controller, datapath.
// Depends on gcva_pkg, gcva_ctrl and gcva_dp.
// An accumulate item passes the read and update states; a read item likewise, and
// in mean mode, when a division runs, also the divide and output states (one
// quotient bit a cycle). After reset all cell flags are cleared with busy high.
// The receiver cannot stall: done marks each result for exactly one cycle.
module grid_cell_value_aggregator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	input  logic               action,
	input  logic [7:0]         row,
	input  logic [7:0]         col,
	input  logic signed [31:0] sample_value,
	input  logic [23:0]        sample_area,
	output logic signed [31:0] cell_value,
	output logic               cell_empty,
	output logic               done
);
	import gcva_pkg::*;

	logic [1:0] mode_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MIN;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	gcva_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .cmd, .sts);

	gcva_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .mode(mode_q), .action, .row, .col,
		.sample_value, .sample_area, .cell_value, .cell_empty, .done
	);
endmodule

// ===== tb/gcva_checker.sv =====
// Checker for the grid cell value aggregator: watches the item, register and result ports.
// It predicts each read result from its own copy of the cell store and compares field by field.
// Depends on gcva_pkg.
module gcva_checker
	import gcva_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	input  logic               action,
	input  logic [7:0]         row,
	input  logic [7:0]         col,
	input  logic signed [31:0] sample_value,
	input  logic [23:0]        sample_area,
	input  logic signed [31:0] cell_value,
	input  logic               cell_empty,
	input  logic               done,
	output int                 fail_count,
	output int                 pending
);
	typedef struct {
		logic signed [31:0] value;
		logic               empty;
	} cell_result_t;

	bit                 cell_used [DEPTH];
	logic        [39:0] area_sum [DEPTH];
	logic signed [63:0] cell_acc [DEPTH];
	mode_t              agg_mode;
	cell_result_t       expected_cells[$];

	assign pending = expected_cells.size();

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		fail_count++;
	endtask

	function automatic logic signed [63:0] add_sat64(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return s[63:0];
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] weighted_mean(logic signed [63:0] acc, logic [39:0] area);
		logic [63:0] mag;
		logic [63:0] q;
		mag = acc[63] ? 64'd0 - acc : acc;
		q = mag / {24'd0, area};
		if (acc[63]) begin
			if (q > 64'h8000_0000) return 32'sh8000_0000;
			return -q[31:0];
		end
		if (q > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
		return q[31:0];
	endfunction

	task automatic fold_sample(input logic [15:0] idx, input logic signed [31:0] v,
			input logic [23:0] a);
		logic signed [63:0] contrib;
		logic        [40:0] tot;
		contrib = (agg_mode == MODE_MEAN) ? 64'(v) * $signed({40'd0, a}) : 64'(v);
		if (!cell_used[idx]) begin
			cell_used[idx] = 1'b1;
			area_sum[idx] = {16'd0, a};
			cell_acc[idx] = contrib;
			return;
		end
		tot = {1'b0, area_sum[idx]} + a;
		area_sum[idx] = tot[40] ? 40'hFF_FFFF_FFFF : tot[39:0];
		case (agg_mode)
			MODE_MIN: if (contrib < cell_acc[idx]) cell_acc[idx] = contrib;
			MODE_MAX: if (contrib > cell_acc[idx]) cell_acc[idx] = contrib;
			default:  cell_acc[idx] = add_sat64(cell_acc[idx], contrib);
		endcase
	endtask

	function automatic cell_result_t read_cell(input logic [15:0] idx);
		cell_result_t r;
		r.value = '0;
		r.empty = 1'b1;
		if (!cell_used[idx]) return r;
		r.empty = 1'b0;
		if (area_sum[idx] != 0)
			r.value = (agg_mode == MODE_MEAN) ? weighted_mean(cell_acc[idx], area_sum[idx])
				: clamp32(cell_acc[idx]);
		cell_used[idx] = 1'b0;
		area_sum[idx] = '0;
		cell_acc[idx] = '0;
		return r;
	endfunction

	initial begin
		fail_count = 0;
		agg_mode = MODE_MIN;
		foreach (cell_used[i]) cell_used[i] = 1'b0;
	end

	always @(posedge clk) begin
		cell_result_t exp_r;
		if (arst_n) begin
			if (done) begin
				if (expected_cells.size() == 0) begin
					report($sformatf("result with no item waiting: value %0d empty %0b",
						cell_value, cell_empty));
				end else begin
					exp_r = expected_cells.pop_front();
					if (cell_value !== exp_r.value)
						report($sformatf("cell_value %0d, expected %0d", cell_value, exp_r.value));
					if (cell_empty !== exp_r.empty)
						report($sformatf("cell_empty %0b, expected %0b", cell_empty, exp_r.empty));
				end
			end
			if (cfg_we) agg_mode = mode_t'(cfg_wdata);
			if (start && !busy) begin
				if (action == ACT_ACC) fold_sample({row, col}, sample_value, sample_area);
				else expected_cells.insert(expected_cells.size(), read_cell({row, col}));
			end
		end
	end
endmodule

// ===== tb/grid_cell_value_aggregator_top_tb.sv =====
// Testbench top for the grid cell value aggregator: clock, reset, stimulus and verdict.
// Directed items cover every mode and corner, then random phases hammer a few busy cells.
// Depends on gcva_pkg, grid_cell_value_aggregator_top and gcva_checker.
module grid_cell_value_aggregator_top_tb;
	import gcva_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_wdata = '0;
	logic               action = ACT_ACC;
	logic [7:0]         row = '0;
	logic [7:0]         col = '0;
	logic signed [31:0] sample_value = '0;
	logic [23:0]        sample_area = '0;
	logic signed [31:0] cell_value;
	logic               cell_empty;
	logic               done;
	int                 fail_count;
	int                 pending;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	grid_cell_value_aggregator_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .action(action), .row(row), .col(col),
		.sample_value(sample_value), .sample_area(sample_area),
		.cell_value(cell_value), .cell_empty(cell_empty), .done(done)
	);

	gcva_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .action(action), .row(row), .col(col),
		.sample_value(sample_value), .sample_area(sample_area),
		.cell_value(cell_value), .cell_empty(cell_empty), .done(done),
		.fail_count(fail_count), .pending(pending)
	);

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 94) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(input logic act, input logic [7:0] r, input logic [7:0] c,
			input logic signed [31:0] v, input logic [23:0] a, input int gap);
		start <= 1'b1;
		action <= act;
		row <= r;
		col <= c;
		sample_value <= v;
		sample_area <= a;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic set_mode(input mode_t m);
		if (start) begin
			start <= 1'b0;
			@(posedge clk);
		end
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd7;
			3: return 8'd128;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [23:0] pick_area();
		case ($urandom_range(0, 5))
			0: return 24'd0;
			1: return 24'hFF_FFFF;
			2: return 24'($urandom_range(1, 24'h2_0000));
			default: return 24'($urandom());
		endcase
	endfunction

	initial begin
		int idle;
		mode_t m;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		for (int k = 0; k < 4; k++) begin
			set_mode(mode_t'(k));
			send_item(ACT_ACC, 8'd0, 8'd0, 32'sh7FFF_FFFF, 24'hFF_FFFF, 0);
			send_item(ACT_ACC, 8'd0, 8'd0, 32'sh7FFF_FFFF, 24'h01_0000, 0);
			send_item(ACT_ACC, 8'd255, 8'd255, 32'sh8000_0000, 24'h00_0001, 1);
			send_item(ACT_ACC, 8'd255, 8'd255, 32'sh8000_0000, 24'd0, 0);
			send_item(ACT_READ, 8'd0, 8'd0, '0, '0, 0);
			send_item(ACT_READ, 8'd255, 8'd255, '0, '0, 0);
		end
		send_item(ACT_ACC, 8'd9, 8'd9, 32'sh0001_0000, 24'd0, 0);
		send_item(ACT_READ, 8'd9, 8'd9, '0, '0, 0);
		send_item(ACT_READ, 8'd9, 8'd9, '0, '0, 2);
		send_item(ACT_ACC, 8'd4, 8'd5, -32'sh0003_0000, 24'h00_8000, 0);
		set_mode(MODE_MIN);
		send_item(ACT_ACC, 8'd4, 8'd5, 32'sh0000_1000, 24'h00_8000, 0);
		send_item(ACT_READ, 8'd4, 8'd5, '0, '0, 0);

		for (int ph = 0; ph < 10; ph++) begin
			m = (ph < 4) ? mode_t'(3 - ph) : mode_t'($urandom_range(0, 3));
			set_mode(m);
			idle = $urandom_range(0, 2);
			for (int i = 0; i < 100; i++) begin
				send_item(($urandom_range(0, 3) == 0) ? ACT_READ : ACT_ACC,
					pick_coord(), pick_coord(), pick_value(), pick_area(),
					idle == 0 ? 0 : gap_len());
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end
endmodule
